// ----- design/swg_pkg.sv -----
// Shared widths, constants and types for the SwiGLU activation unit.
package swg_pkg;

   localparam int unsigned DATA_W   = 16;
   localparam int unsigned GU_W     = 2 * DATA_W;
   localparam int unsigned P_W      = 18;
   localparam int unsigned K_W      = 8;
   localparam int unsigned DEN_W    = 43;
   localparam int unsigned NUM_W    = 59;
   localparam int unsigned Q_W      = 17;
   localparam int unsigned K_LIMIT  = 24;

   localparam logic signed [17:0] LOG2E_Q16      = 18'sd94548;
   localparam logic signed [17:0] LN2_Q16        = 18'sd45426;
   localparam logic signed [17:0] HALF_Q16       = 18'sd32768;
   localparam logic signed [17:0] SIXTH_Q16      = 18'sd10923;
   localparam logic signed [17:0] TWENTYFOURTH_Q16 = 18'sd2731;

   // Sideband that rides alongside the sigmoid: up*gate and the vector marker.
   typedef struct packed {
      logic signed [GU_W-1:0] gate_up;
      logic                   last;
   } side_type;

endpackage

// ----- design/swg_sig_front.sv -----
// Sigmoid front end: exponent split, Taylor series for 2^r, divider operands.
module swg_sig_front
   import swg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [DATA_W-1:0] gate,
   input  logic signed [DATA_W-1:0] up,
   input  logic                    last,
   output logic                    out_valid,
   output logic [NUM_W-1:0]        num,
   output logic [DEN_W-1:0]        den,
   output side_type                side
);

   // round to nearest, ties upward, by 2^16
   function automatic logic signed [15:0] rnd16(input logic signed [33:0] v);
      logic signed [33:0] w;
      w = (v + 34'sd32768) >>> 16;
      return w[15:0];
   endfunction

   logic [6:0] v_ff;
   side_type   s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff;

   // stage 1: x = gate * log2(e), clamped
   logic signed [33:0] px;
   logic signed [33:0] xr;
   logic signed [23:0] x_in, x_ff;
   side_type           s1_in;

   always_comb begin
      px = gate * LOG2E_Q16;
      xr = (px + 34'sd128) >>> 8;
      if (xr < -34'sd8388608) begin
         x_in = -24'sd8388608;
      end else if (xr > 34'sd8323072) begin
         x_in = 24'sd8323072;
      end else begin
         x_in = xr[23:0];
      end
      s1_in.gate_up = gate * up;
      s1_in.last    = last;
   end

   // stage 2: split into k and r, t = r * ln2
   logic signed [24:0]  xs;
   logic signed [15:0]  r;
   logic signed [33:0]  pt;
   logic signed [K_W-1:0] k_in, k2_ff, k3_ff, k4_ff, k5_ff, k6_ff;
   logic signed [15:0]  t_in, t2_ff_t, t3_ff_t, t4_ff_t, t5_ff_t;

   always_comb begin
      xs   = {x_ff[23], x_ff} + 25'sd32768;
      k_in = xs[23:16];
      r    = {~xs[15], xs[14:0]};
      pt   = r * LN2_Q16;
      t_in = rnd16(pt);
   end

   // stages 3 to 5: powers of t and their weighted terms
   logic signed [15:0] tsq_in, tsq3_ff, tsq4_ff;
   logic signed [15:0] tcu_in, tcu4_ff;
   logic signed [15:0] tqu_in, hq_in, sx_in, tqu5_ff, hq5_ff, sx5_ff;

   always_comb begin
      tsq_in = rnd16(34'(t2_ff_t * t2_ff_t));
      tcu_in = rnd16(34'(tsq3_ff * t3_ff_t));
      tqu_in = rnd16(34'(tcu4_ff * t4_ff_t));
      hq_in  = rnd16(34'(tsq4_ff * HALF_Q16));
      sx_in  = rnd16(34'(tcu4_ff * SIXTH_Q16));
   end

   // stage 6: p = 2^r in Q.16
   logic signed [15:0] w4;
   logic signed [19:0] psum;
   logic [P_W-1:0]     p_ff;

   always_comb begin
      w4   = rnd16(34'(tqu5_ff * TWENTYFOURTH_Q16));
      psum = 20'sd65536 + 20'(t5_ff_t) + 20'(hq5_ff) + 20'(sx5_ff) + 20'(w4);
   end

   // stage 7: divider operands
   logic signed [K_W-1:0] kc, nk;
   logic [DEN_W-2:0]      a, b;
   logic [DEN_W-1:0]      den_in;
   logic [NUM_W-1:0]      num_in;

   always_comb begin
      if (k6_ff > 8'sd24) begin
         kc = 8'sd24;
      end else if (k6_ff < -8'sd24) begin
         kc = -8'sd24;
      end else begin
         kc = k6_ff;
      end
      nk = -kc;
      if (kc >= 8'sd0) begin
         a = (DEN_W-1)'(p_ff) << kc[4:0];
         b = (DEN_W-1)'(65536);
      end else begin
         a = (DEN_W-1)'(p_ff);
         b = (DEN_W-1)'(65536) << nk[4:0];
      end
      den_in = {1'b0, a} + {1'b0, b};
      num_in = {1'b0, a, 16'b0} + NUM_W'(den_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      s1_ff   <= s1_in;
      k2_ff   <= k_in;
      t2_ff_t <= t_in;
      s2_ff   <= s1_ff;
      tsq3_ff <= tsq_in;
      t3_ff_t <= t2_ff_t;
      k3_ff   <= k2_ff;
      s3_ff   <= s2_ff;
      tcu4_ff <= tcu_in;
      tsq4_ff <= tsq3_ff;
      t4_ff_t <= t3_ff_t;
      k4_ff   <= k3_ff;
      s4_ff   <= s3_ff;
      tqu5_ff <= tqu_in;
      hq5_ff  <= hq_in;
      sx5_ff  <= sx_in;
      t5_ff_t <= t4_ff_t;
      k5_ff   <= k4_ff;
      s5_ff   <= s4_ff;
      p_ff    <= psum[P_W-1:0];
      k6_ff   <= k5_ff;
      s6_ff   <= s5_ff;
      num     <= num_in;
      den     <= den_in;
      s7_ff   <= s6_ff;
   end

   assign out_valid = v_ff[6];
   assign side      = s7_ff;

endmodule

// ----- design/swg_divider.sv -----
// Restoring divider, one quotient bit per pipeline stage.
module swg_divider
   import swg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    quot,
   output side_type          out_side
);

   logic [NUM_W-1:0] rem_ff  [0:Q_W-2];
   logic [DEN_W-1:0] den_ff  [0:Q_W-2];
   logic [Q_W-1:0]   q_ff    [0:Q_W-1];
   side_type         side_ff [0:Q_W-1];
   logic             v_ff    [0:Q_W-1];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      localparam int unsigned BIT = Q_W - 1 - j;
      logic [NUM_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [Q_W-1:0]   q_cur;
      side_type         side_cur;
      logic             v_cur;
      logic [NUM_W-1:0] trial;
      logic             take;
      logic [Q_W-1:0]   q_in;

      // first stage takes the operands straight from the ports
      if (j == 0) begin : g_head
         assign rem_cur  = num;
         assign den_cur  = den;
         assign q_cur    = '0;
         assign side_cur = in_side;
         assign v_cur    = in_valid;
      end else begin : g_body
         assign rem_cur  = rem_ff[j-1];
         assign den_cur  = den_ff[j-1];
         assign q_cur    = q_ff[j-1];
         assign side_cur = side_ff[j-1];
         assign v_cur    = v_ff[j-1];
      end

      always_comb begin
         trial  = NUM_W'(den_cur) << BIT;
         take   = rem_cur >= trial;
         q_in   = q_cur;
         q_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         q_ff[j]    <= q_in;
         side_ff[j] <= side_cur;
      end

      // the last stage needs no remainder
      if (j < Q_W - 1) begin : g_pass
         always_ff @(posedge clock) begin
            rem_ff[j] <= take ? rem_cur - trial : rem_cur;
            den_ff[j] <= den_cur;
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign quot      = q_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ----- design/swiglu_gated_activation_unit.sv -----
// SwiGLU activation unit: up * gate * sigmoid(gate) in Q8.8, fully pipelined.
// Pipeline: input register, 7 sigmoid stages, 17 divider stages, product, output.
// Throughput: one element per cycle; busy is never raised and results cannot be held off.
// Reset (synchronous, active high) empties the pipeline: all valid bits clear, data keeps.
module swiglu_gated_activation_unit
   import swg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_gate_value,
   input  logic signed [DATA_W-1:0] req_up_value,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_activated,
   output logic                     rsp_last_out
);

   // The pipeline never stalls, so every start is taken.
   assign busy = 1'b0;

   // Input register: hold the transfer for the sigmoid front end.
   logic                     in_v_ff;
   logic signed [DATA_W-1:0] gate_ff, up_ff;
   logic                     last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      gate_ff <= req_gate_value;
      up_ff   <= req_up_value;
      last_ff <= req_is_last;
   end

   // Sigmoid numerator and denominator; gate*up travels alongside.
   logic             fr_valid;
   logic [NUM_W-1:0] fr_num;
   logic [DEN_W-1:0] fr_den;
   side_type         fr_side;

   swg_sig_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .gate      (gate_ff),
      .up        (up_ff),
      .last      (last_ff),
      .out_valid (fr_valid),
      .num       (fr_num),
      .den       (fr_den),
      .side      (fr_side)
   );

   // Divide to get the sigmoid in Q0.16, range [0, 65536].
   logic           dv_valid;
   logic [Q_W-1:0] sig;
   side_type       dv_side;

   swg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .num       (fr_num),
      .den       (fr_den),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .quot      (sig),
      .out_side  (dv_side)
   );

   // Exact product gate*up*sig, registered before the single rounding.
   logic                 pr_v_ff;
   logic signed [49:0]   prod_in, prod_ff;
   logic                 pr_last_ff;

   assign prod_in = dv_side.gate_up * $signed({1'b0, sig});

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else begin
         pr_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      pr_last_ff <= dv_side.last;
   end

   // Round to nearest by 2^24, then saturate to Q8.8.
   logic signed [49:0]       rnd;
   logic signed [DATA_W-1:0] act_in;

   always_comb begin
      rnd = (prod_ff + 50'sd8388608) >>> 24;
      if (rnd > 50'sd32767) begin
         act_in = 16'sd32767;
      end else if (rnd < -50'sd32768) begin
         act_in = -16'sd32768;
      end else begin
         act_in = rnd[DATA_W-1:0];
      end
   end

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_act_ff;
   logic                     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_act_ff  <= act_in;
      rsp_last_ff <= pr_last_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_activated = rsp_act_ff;
   assign rsp_last_out  = rsp_last_ff;

endmodule

// ----- tb/tb_swiglu_gated_activation_unit.sv -----
// Testbench for the SwiGLU activation unit: streamed stimulus against a fixed-point predictor.
`timescale 1ns / 100ps

module tb_swiglu_gated_activation_unit;
   import swg_pkg::*;

   // One element on the request side.
   typedef struct {
      logic signed [DATA_W-1:0] gate;
      logic signed [DATA_W-1:0] up;
      logic                     last;
   } element_type;

   // One expected activation.
   typedef struct {
      logic signed [DATA_W-1:0] activated;
      logic                     last;
   } activation_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_gate_value = '0;
   logic signed [DATA_W-1:0] req_up_value = '0;
   logic                     req_is_last = 1'b0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_activated;
   logic                     rsp_last_out;

   element_type    pending_elements[$];
   activation_type expected_activations[$];
   int          error_count = 0;
   int          idle_percent = 0;   // chance per cycle that the sender holds off
   bit          drain_hold = 1'b0;  // hold the sender until the pipeline has emptied
   bit          stimulus_done = 1'b0;

   swiglu_gated_activation_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_gate_value (req_gate_value),
      .req_up_value   (req_up_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_activated  (rsp_activated),
      .rsp_last_out   (rsp_last_out)
   );

   always #5 clock = ~clock;

   // floor((v + 2^(s-1)) / 2^s); >>> on a signed longint is an arithmetic floor shift.
   function automatic longint round_shift(longint v, int s);
      longint w;
      w = v + (64'sd1 <<< (s - 1));
      return w >>> s;
   endfunction

   // Sigmoid of a Q8.8 gate as unsigned Q0.16 in [0, 65536].
   function automatic longint sigmoid_q16(longint gate);
      longint x, k, r, t, t2, t3, t4, p;
      longint unsigned a, b, den, q;
      x = round_shift(gate * 94548, 8);
      if (x < -128 * 65536) x = -128 * 65536;
      if (x > 127 * 65536) x = 127 * 65536;
      k = round_shift(x, 16);
      r = x - k * 65536;
      t = round_shift(r * 45426, 16);
      t2 = round_shift(t * t, 16);
      t3 = round_shift(t2 * t, 16);
      t4 = round_shift(t3 * t, 16);
      p = 65536 + t + round_shift(t2 * 32768, 16) + round_shift(t3 * 10923, 16)
          + round_shift(t4 * 2731, 16);
      if (k > longint'(K_LIMIT)) k = longint'(K_LIMIT);
      if (k < -longint'(K_LIMIT)) k = -longint'(K_LIMIT);
      a = p;
      b = 64'd1 << 16;
      if (k >= 0) a = a << k;
      else b = b << (-k);
      den = a + b;
      q = ((a << 16) + (den >> 1)) / den;
      return longint'(q);
   endfunction

   // Work out the saturated Q8.8 activation for one element.
   function automatic activation_type predict_activation(element_type e);
      activation_type res;
      longint      g, prod, v;
      g = e.gate;
      prod = g * sigmoid_q16(g) * longint'(e.up);
      v = round_shift(prod, 24);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res.activated = v[DATA_W-1:0];
      res.last = e.last;
      return res;
   endfunction

   function automatic element_type make_element(int gate, int up, bit last);
      element_type e;
      e.gate = gate[DATA_W-1:0];
      e.up = up[DATA_W-1:0];
      e.last = last;
      return e;
   endfunction

   // Random element: mostly gates in the interesting sigmoid band, some over the full range.
   function automatic element_type random_element();
      int gate, up;
      case ($urandom_range(0, 3))
         0: gate = $urandom_range(0, 65535) - 32768;
         1: gate = $urandom_range(0, 8192) - 4096;
         2: gate = $urandom_range(0, 1024) - 512;
         default: gate = $urandom_range(0, 16384) - 8192;
      endcase
      if ($urandom_range(0, 1)) up = $urandom_range(0, 65535) - 32768;
      else up = $urandom_range(0, 1024) - 512;
      return make_element(gate, up, $urandom_range(0, 7) == 0);
   endfunction

   // Driver: present the next element, or hold off at random; advance on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) pending_elements.pop_front();
         if (pending_elements.size() > 0 && !drain_hold &&
             $urandom_range(0, 99) >= idle_percent) begin
            start <= 1'b1;
            req_gate_value <= pending_elements[0].gate;
            req_up_value <= pending_elements[0].up;
            req_is_last <= pending_elements[0].last;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Record the expectation for each start transfer.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         element_type e;
         e.gate = req_gate_value;
         e.up = req_up_value;
         e.last = req_is_last;
         expected_activations.push_back(predict_activation(e));
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_activations.size() == 0) begin
            $error("unexpected result: activated=%0d last_out=%0b", rsp_activated,
                   rsp_last_out);
            error_count++;
         end else begin
            activation_type exp_act;
            exp_act = expected_activations.pop_front();
            if (rsp_activated !== exp_act.activated) begin
               $error("activated: expected %0d, actual %0d", exp_act.activated,
                      rsp_activated);
               error_count++;
            end
            if (rsp_last_out !== exp_act.last) begin
               $error("last_out: expected %0b, actual %0b", exp_act.last, rsp_last_out);
               error_count++;
            end
         end
      end
   end

   // Wait until the driver has handed over everything queued.
   task automatic wait_queue_empty();
      while (pending_elements.size() > 0 || start) @(posedge clock);
   endtask

   // Queue a batch of random elements with the given hold-off rate, and let it go out.
   task automatic run_phase(int count, int idle);
      idle_percent = idle;
      repeat (count) pending_elements.push_back(random_element());
      wait_queue_empty();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, saturation both ways, clamp at both ends, zero and near-zero.
      pending_elements.push_back(make_element(0, 0, 0));
      pending_elements.push_back(make_element(32767, 32767, 1));
      pending_elements.push_back(make_element(32767, -32768, 0));
      pending_elements.push_back(make_element(-32768, 32767, 1));
      pending_elements.push_back(make_element(-32768, -32768, 0));
      pending_elements.push_back(make_element(256, 256, 0));
      pending_elements.push_back(make_element(-256, 256, 1));
      pending_elements.push_back(make_element(1, 32767, 0));
      pending_elements.push_back(make_element(-1, -32768, 0));
      pending_elements.push_back(make_element(5000, 32767, 0));
      pending_elements.push_back(make_element(5000, -32768, 1));
      pending_elements.push_back(make_element(-5000, 32767, 0));
      pending_elements.push_back(make_element(2000, 1000, 0));
      pending_elements.push_back(make_element(-2000, 1000, 0));
      pending_elements.push_back(make_element(128, -1, 1));
      pending_elements.push_back(make_element(-128, 12345, 0));
      pending_elements.push_back(make_element(21845, 21845, 0));
      pending_elements.push_back(make_element(-21846, -21846, 1));
      wait_queue_empty();

      // Hold the sender until every outstanding result has arrived.
      drain_hold = 1'b1;
      while (expected_activations.size() > 0) @(posedge clock);
      drain_hold = 1'b0;

      run_phase(300, 0);
      run_phase(250, 81);
      run_phase(200, 30);
      run_phase(250, 0);
      stimulus_done = 1'b1;
   end

   // End of run: drain, allow for the pipeline depth, then report.
   initial begin
      wait (stimulus_done);
      while (expected_activations.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Time-out well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- swiglu_gated_activation_unit.f -----
design/swg_pkg.sv
design/swg_sig_front.sv
design/swg_divider.sv
design/swiglu_gated_activation_unit.sv
tb/tb_swiglu_gated_activation_unit.sv
